/* rtl/core/aip_pkg.sv */
`default_nettype none
package aip_pkg;

  // Number base codes; the unused code behaves as decimal.
  localparam logic [1:0] BASE_OCT = 2'd0;
  localparam logic [1:0] BASE_DEC = 2'd1;
  localparam logic [1:0] BASE_HEX = 2'd2;

  // Width part of the type code (type_select[2:1]); bit 0 set means unsigned.
  localparam logic [1:0] WIDTH_8  = 2'd0;
  localparam logic [1:0] WIDTH_16 = 2'd1;
  localparam logic [1:0] WIDTH_32 = 2'd2;
  localparam logic [1:0] WIDTH_64 = 2'd3;

  // Register indexes on the configuration port (byte address bits [3:2]).
  localparam logic [1:0] REG_BASE   = 2'd0;
  localparam logic [1:0] REG_TYPE   = 2'd1;
  localparam logic [1:0] REG_NEGATE = 2'd2;

  localparam logic [1:0] RESET_BASE   = BASE_DEC;
  localparam logic [2:0] RESET_TYPE   = 3'd7;
  localparam logic       RESET_NEGATE = 1'b0;

  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_UPPERA = 8'h41;
  localparam logic [7:0] CHAR_UPPERF = 8'h46;
  localparam logic [7:0] CHAR_LOWERA = 8'h61;
  localparam logic [7:0] CHAR_LOWERF = 8'h66;

  localparam logic [4:0] DIGIT_BAD = 5'd16;

  // A finished string handed from the accumulator to the output stage.
  typedef struct packed {
    logic [63:0] acc;
    logic        bad;
    logic [2:0]  type_sel;
    logic        neg;
  } fin_t;

  // Digit value of a character in the given base, or DIGIT_BAD.
  function automatic logic [4:0] digit_of(input logic [7:0] c, input logic [1:0] base);
    logic [7:0] t;
    logic [4:0] d;
    logic [4:0] lim;
    t = 8'd0;
    d = DIGIT_BAD;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      t = c - CHAR_ZERO;
      d = t[4:0];
    end else if (c >= CHAR_UPPERA && c <= CHAR_UPPERF) begin
      t = c - CHAR_UPPERA + 8'd10;
      d = t[4:0];
    end else if (c >= CHAR_LOWERA && c <= CHAR_LOWERF) begin
      t = c - CHAR_LOWERA + 8'd10;
      d = t[4:0];
    end
    case (base)
      BASE_OCT: lim = 5'd8;
      BASE_HEX: lim = 5'd16;
      default:  lim = 5'd10;
    endcase
    if (d >= lim) begin
      d = DIGIT_BAD;
    end
    return d;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/ascii_integer_parser.sv */
// A word that ends a string passes the input, finish and result registers before its
// result appears. Throughput: one character word per cycle while char_stall is low;
// the accumulator's multiply-add of 8, 10 or 16 times the value plus the digit is
// combinational. Reset (synchronous, active high) empties all three stages, clears the
// accumulator and flags, and sets the registers to decimal base, u64 type and no negation.
`default_nettype none
module ascii_integer_parser (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         char_valid,
  output logic              char_stall,
  input  wire logic [7:0]   char_code,
  input  wire logic         no_char,
  input  wire logic         end_of_string,
  output logic              result_valid,
  input  wire logic         result_stall,
  output logic              status,
  output logic [63:0]       value_bits,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import aip_pkg::*;

  logic [1:0] base_select;
  logic [2:0] type_select;
  logic       negate_result;

  logic       a_valid;
  logic [7:0] a_char;
  logic       a_no_char;
  logic       a_end;
  logic       acc_ready;
  logic       word_valid;
  logic       fin_valid;
  fin_t       fin;
  logic       fin_ready;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_select   <= RESET_BASE;
      type_select   <= RESET_TYPE;
      negate_result <= RESET_NEGATE;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_BASE:   base_select   <= pwdata[1:0];
        REG_TYPE:   type_select   <= pwdata[2:0];
        REG_NEGATE: negate_result <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_BASE:   prdata = {30'd0, base_select};
      REG_TYPE:   prdata = {29'd0, type_select};
      REG_NEGATE: prdata = {31'd0, negate_result};
      default:    prdata = 32'd0;
    endcase
  end

  // Input register: holds one word while the accumulator stage is blocked.
  assign word_valid = a_valid && acc_ready;
  assign char_stall = a_valid && !acc_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (!char_stall) begin
      a_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && !char_stall) begin
      a_char    <= char_code;
      a_no_char <= no_char;
      a_end     <= end_of_string;
    end
  end

  aip_accumulate u_accumulate (
    .clk           (clk),
    .rst           (rst),
    .word_valid    (word_valid),
    .char_code     (a_char),
    .no_char       (a_no_char),
    .end_of_string (a_end),
    .base_select   (base_select),
    .type_select   (type_select),
    .negate_result (negate_result),
    .ready         (acc_ready),
    .fin_valid     (fin_valid),
    .fin           (fin),
    .fin_ready     (fin_ready)
  );

  aip_finish u_finish (
    .clk          (clk),
    .rst          (rst),
    .fin_valid    (fin_valid),
    .fin          (fin),
    .fin_ready    (fin_ready),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .value_bits   (value_bits)
  );

  a_error_zero : assert property (@(posedge clk) disable iff (rst)
    result_valid && status |-> value_bits == 64'd0)
    else $error("error result carries a non-zero value");

  a_end_reaches_fin : assert property (@(posedge clk) disable iff (rst)
    word_valid && a_end |=> fin_valid)
    else $error("end of string did not reach the finish stage");

  a_stall_only_full : assert property (@(posedge clk) disable iff (rst)
    char_stall |-> a_valid && fin_valid)
    else $error("input stalled with room in the pipeline");

  a_reset_empty : assert property (@(posedge clk)
    $fell(rst) |-> !result_valid && !fin_valid && !a_valid)
    else $error("pipeline not empty after reset");

endmodule
`default_nettype wire

/* rtl/core/aip_accumulate.sv */
`default_nettype none
module aip_accumulate (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         word_valid,
  input  wire logic [7:0]   char_code,
  input  wire logic         no_char,
  input  wire logic         end_of_string,
  input  wire logic [1:0]   base_select,
  input  wire logic [2:0]   type_select,
  input  wire logic         negate_result,
  output logic              ready,
  output logic              fin_valid,
  output aip_pkg::fin_t     fin,
  input  wire logic         fin_ready
);
  import aip_pkg::*;

  logic [63:0] acc;
  logic        err;
  logic        seen;
  logic [63:0] acc_next;
  logic        err_next;
  logic        seen_next;
  logic [4:0]  digit;
  logic [67:0] prod;
  logic [67:0] sum;
  logic        ovf;

  assign ready = !fin_valid || fin_ready;

  always_comb begin
    digit = digit_of(char_code, base_select);
    case (base_select)
      BASE_OCT: prod = {1'b0, acc, 3'b000};
      BASE_HEX: prod = {acc, 4'b0000};
      default:  prod = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0};
    endcase
    sum = prod + {63'd0, digit};
    // Anything above bit 63 means the value no longer fits in 64 bits.
    ovf = |sum[67:64];

    acc_next  = acc;
    err_next  = err;
    seen_next = seen;
    if (!no_char) begin
      seen_next = 1'b1;
      if (digit == DIGIT_BAD) begin
        err_next = 1'b1;
      end else if (!err) begin
        if (ovf) begin
          err_next = 1'b1;
        end else begin
          acc_next = sum[63:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= 64'd0;
      err       <= 1'b0;
      seen      <= 1'b0;
      fin_valid <= 1'b0;
    end else begin
      if (word_valid) begin
        if (end_of_string) begin
          acc  <= 64'd0;
          err  <= 1'b0;
          seen <= 1'b0;
        end else begin
          acc  <= acc_next;
          err  <= err_next;
          seen <= seen_next;
        end
      end
      if (word_valid && end_of_string) begin
        fin_valid <= 1'b1;
      end else if (fin_ready) begin
        fin_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (word_valid && end_of_string) begin
      fin.acc      <= acc_next;
      fin.bad      <= err_next || !seen_next;
      fin.type_sel <= type_select;
      fin.neg      <= negate_result;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/aip_finish.sv */
`default_nettype none
module aip_finish (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         fin_valid,
  input  aip_pkg::fin_t     fin,
  output logic              fin_ready,
  output logic              result_valid,
  input  wire logic         result_stall,
  output logic              status,
  output logic [63:0]       value_bits
);
  import aip_pkg::*;

  logic [63:0] mask;
  logic [63:0] limit;
  logic [63:0] v;
  logic [63:0] ext;
  logic        is_signed;
  logic        bad;

  assign fin_ready = !result_valid || !result_stall;

  always_comb begin
    is_signed = !fin.type_sel[0];
    case (fin.type_sel[2:1])
      WIDTH_8:  mask = 64'h0000_0000_0000_00FF;
      WIDTH_16: mask = 64'h0000_0000_0000_FFFF;
      WIDTH_32: mask = 64'h0000_0000_FFFF_FFFF;
      default:  mask = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    // A negated signed value may reach one past the positive limit.
    if (is_signed) begin
      limit = (mask >> 1) + {63'd0, fin.neg};
    end else begin
      limit = mask;
    end
    bad = fin.bad || (fin.acc > limit);
    v = fin.neg ? (64'd0 - fin.acc) : fin.acc;
    case (fin.type_sel[2:1])
      WIDTH_8:  ext = {{56{is_signed & v[7]}}, v[7:0]};
      WIDTH_16: ext = {{48{is_signed & v[15]}}, v[15:0]};
      WIDTH_32: ext = {{32{is_signed & v[31]}}, v[31:0]};
      default:  ext = v;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fin_ready) begin
      result_valid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_valid && fin_ready) begin
      status     <= bad;
      value_bits <= bad ? 64'd0 : ext;
    end
  end

endmodule
`default_nettype wire

/* sim/tb_ascii_integer_parser.sv */
`timescale 1ns / 1ps

module tb_ascii_integer_parser;
  import aip_pkg::*;

  localparam logic [1:0] BASE_SPARE = 2'd3;
  localparam logic [2:0] TYPE_S8  = {WIDTH_8, 1'b0};
  localparam logic [2:0] TYPE_U8  = {WIDTH_8, 1'b1};
  localparam logic [2:0] TYPE_U64 = {WIDTH_64, 1'b1};
  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 550;

  typedef struct packed {
    logic [7:0] code;
    logic       no_char;
    logic       eos;
    logic       hold;
  } char_word_t;

  typedef struct packed {
    logic        status;
    logic [63:0] value;
  } parse_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        char_valid = 1'b0;
  logic        char_stall;
  logic [7:0]  char_code = 8'd0;
  logic        no_char = 1'b0;
  logic        end_of_string = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic        status;
  logic [63:0] value_bits;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  ascii_integer_parser i_dut (
    .clk           (clk),
    .rst           (rst),
    .char_valid    (char_valid),
    .char_stall    (char_stall),
    .char_code     (char_code),
    .no_char       (no_char),
    .end_of_string (end_of_string),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .status        (status),
    .value_bits    (value_bits),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Words waiting to be sent, and the parse results still owed by the block.
  char_word_t    char_words[$];
  parse_result_t expected_results[$];
  char_word_t    cur_word;

  // Shadow of the parser's registers and string state.
  logic [1:0]  cfg_base = RESET_BASE;
  logic [2:0]  cfg_type = RESET_TYPE;
  logic        cfg_neg = RESET_NEGATE;
  logic [63:0] acc_q = 64'd0;
  bit          err_q = 1'b0;
  bit          seen_q = 1'b0;

  int fail_count = 0;
  int planned = 0;
  int cycle_no = 0;
  int gap_left = 0;
  int stall_left = 0;
  int quiet = 0;

  always @(posedge clk) cycle_no <= cycle_no + 1;

  function automatic int radix_now();
    case (cfg_base)
      BASE_OCT: return 8;
      BASE_HEX: return 16;
      default:  return 10;
    endcase
  endfunction

  // Value of a character as a hexadecimal digit, 31 if it is none.
  function automatic logic [4:0] char_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 5'(c - "0");
    if (c >= "A" && c <= "F") return 5'(c - "A" + 8'd10);
    if (c >= "a" && c <= "f") return 5'(c - "a" + 8'd10);
    return 5'd31;
  endfunction

  function automatic logic [63:0] type_mask(input logic [2:0] t);
    int bits;
    bits = 8 << t[2:1];
    return (bits == 64) ? '1 : (64'd1 << bits) - 64'd1;
  endfunction

  // Signed types accept one more in magnitude when the result is negated.
  function automatic logic [63:0] type_limit(input logic [2:0] t, input logic n);
    logic [63:0] m;
    m = type_mask(t);
    return t[0] ? m : (m >> 1) + 64'(n);
  endfunction

  task automatic fold_char_word(input char_word_t w);
    logic [67:0]   wide;
    logic [4:0]    d;
    logic [63:0]   mask;
    logic [63:0]   v;
    int            radix;
    int            bits;
    parse_result_t res;
    if (!w.no_char) begin
      radix = radix_now();
      d = char_digit(w.code);
      seen_q = 1'b1;
      if (int'(d) >= radix) begin
        err_q = 1'b1;
      end else if (!err_q) begin
        wide = {4'd0, acc_q} * 68'(radix) + 68'(d);
        if (wide[67:64] != 4'd0) err_q = 1'b1;
        else acc_q = wide[63:0];
      end
    end
    if (w.eos) begin
      if (err_q || !seen_q || acc_q > type_limit(cfg_type, cfg_neg)) begin
        res.status = 1'b1;
        res.value = 64'd0;
      end else begin
        mask = type_mask(cfg_type);
        bits = 8 << cfg_type[2:1];
        v = cfg_neg ? 64'd0 - acc_q : acc_q;
        v &= mask;
        if (!cfg_type[0] && bits < 64 && v[bits-1]) v |= ~mask;
        res.status = 1'b0;
        res.value = v;
      end
      expected_results.push_back(res);
      acc_q = 64'd0;
      err_q = 1'b0;
      seen_q = 1'b0;
    end
  endtask

  // Mostly short idle runs, a few long ones, and none at all in calm stretches.
  function automatic int idle_run();
    int k;
    if (((cycle_no >> 8) % 4) == 0) return 0;
    k = $urandom_range(0, 99);
    if (k < 70) return 0;
    if (k < 95) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (char_valid && !char_stall) fold_char_word(cur_word);
      if (!char_valid || !char_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          char_valid <= 1'b0;
        end else if (char_words.size() > 0 &&
                     !(char_words[0].hold && expected_results.size() != 0)) begin
          cur_word = char_words.pop_front();
          char_valid <= 1'b1;
          char_code <= cur_word.code;
          no_char <= cur_word.no_char;
          end_of_string <= cur_word.eos;
          gap_left = idle_run();
        end else begin
          char_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          $error("result word with no parse result expected");
          fail_count++;
        end else begin
          parse_result_t exp_res;
          exp_res = expected_results.pop_front();
          if (status !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, status);
            fail_count++;
          end
          if (value_bits !== exp_res.value) begin
            $error("value_bits: expected %h, got %h", exp_res.value, value_bits);
            fail_count++;
          end
        end
      end
      if (stall_left == 0) stall_left = idle_run();
      if (stall_left > 0) begin
        stall_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (char_valid && !char_stall) || (result_valid && !result_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("FAIL ascii_integer_parser");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic push_word(input logic [7:0] code, input logic nc, input logic eos,
                           input logic hold = 1'b0);
    char_word_t w;
    w.code = code;
    w.no_char = nc;
    w.eos = eos;
    w.hold = hold;
    char_words.push_back(w);
    planned++;
  endtask

  task automatic push_text(input string s, input logic eos, input logic hold = 1'b0);
    for (int i = 0; i < s.len(); i++) begin
      push_word(s[i], 1'b0, eos && (i == s.len() - 1), hold && (i == 0));
    end
  endtask

  function automatic logic [7:0] digit_char(input int d);
    if (d < 10) return 8'("0" + d);
    return 8'(($urandom_range(0, 1) ? "A" : "a") + d - 10);
  endfunction

  // Writes a value as digits of the current base; an extra digit forces an overflow
  // when the value is already at the top of the 64-bit range.
  task automatic push_number(input logic [63:0] val, input bit extra, input logic hold);
    logic [7:0]  digs[$];
    logic [63:0] rem;
    int          r;
    bit          split;
    r = radix_now();
    rem = val;
    do begin
      digs.push_front(digit_char(int'(rem % 64'(r))));
      rem = rem / 64'(r);
    end while (rem != 0);
    if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) digs.push_front("0");
    if (extra) digs.push_back(digit_char($urandom_range(0, r - 1)));
    split = ($urandom_range(0, 3) == 0);
    foreach (digs[i]) begin
      push_word(digs[i], 1'b0, !split && (i == digs.size() - 1), hold && (i == 0));
    end
    if (split) push_word(8'($urandom_range(0, 255)), 1'b1, 1'b1);
  endtask

  task automatic push_random_string();
    logic [63:0] lim;
    logic        hold;
    int          k;
    int          n;
    int          p;
    int          r;
    lim = type_limit(cfg_type, cfg_neg);
    hold = ($urandom_range(0, 24) == 0);
    r = radix_now();
    k = $urandom_range(0, 99);
    if (k < 55) begin
      case ($urandom_range(0, 6))
        0: push_number(64'd0, 1'b0, hold);
        1: push_number(64'd1, 1'b0, hold);
        2: push_number(lim, 1'b0, hold);
        3: push_number(lim - 64'd1, 1'b0, hold);
        4: begin
          if (lim == '1) push_number(lim, 1'b1, hold);
          else push_number(lim + 64'd1, 1'b0, hold);
        end
        5: push_number({$urandom, $urandom} & type_mask(cfg_type), 1'b0, hold);
        default: push_number({$urandom, $urandom} >> $urandom_range(0, 63), 1'b0, hold);
      endcase
    end else if (k < 70) begin
      n = $urandom_range(1, 24);
      for (int i = 0; i < n; i++) begin
        push_word(digit_char($urandom_range(0, r - 1)), 1'b0, i == n - 1, hold && i == 0);
      end
    end else if (k < 80) begin
      n = $urandom_range(1, 6);
      p = $urandom_range(0, n - 1);
      for (int i = 0; i < n; i++) begin
        push_word((i == p) ? 8'($urandom_range(0, 255)) : digit_char($urandom_range(0, r - 1)),
                  1'b0, i == n - 1, hold && i == 0);
      end
    end else if (k < 85) begin
      push_word(8'($urandom_range(0, 255)), 1'b1, 1'b1, hold);
    end else begin
      // Noise: random words that may leave a string open for the next one.
      repeat ($urandom_range(1, 4)) begin
        push_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_BASE:   cfg_base = data[1:0];
      REG_TYPE:   cfg_type = data[2:0];
      REG_NEGATE: cfg_neg = data[0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [1:0] base, input logic [2:0] ty, input logic neg);
    write_reg(REG_BASE, 32'(base));
    write_reg(REG_TYPE, 32'(ty));
    write_reg(REG_NEGATE, 32'(neg));
  endtask

  // Waits until every word is sent and every result is back, then lets the
  // pipeline empty of words that produce no result.
  task automatic wait_idle();
    do @(posedge clk);
    while (char_words.size() != 0 || char_valid || expected_results.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    int target;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration: decimal, u64, no negation.
    push_text("0", 1'b1);
    push_word(8'h00, 1'b1, 1'b1);
    push_word(8'hA5, 1'b1, 1'b0);
    push_text("7", 1'b1);
    push_word(8'h00, 1'b0, 1'b0);
    push_text("1", 1'b1);
    push_word(8'hFF, 1'b0, 1'b1);
    push_text("9", 1'b0);
    push_word(8'h5A, 1'b1, 1'b1);
    wait_idle();

    configure(BASE_HEX, TYPE_S8, 1'b1);
    push_text("80", 1'b1, 1'b1);
    push_text("aF", 1'b1);
    push_text("7f", 1'b1);
    wait_idle();

    configure(BASE_OCT, TYPE_U8, 1'b1);
    push_text("5", 1'b1);
    push_text("8", 1'b1);
    push_text("377", 1'b1);
    wait_idle();

    // The base changes in the middle of a string.
    configure(BASE_DEC, TYPE_U64, 1'b0);
    push_text("12", 1'b0);
    wait_idle();
    write_reg(REG_BASE, 32'(BASE_HEX));
    push_text("f", 1'b1);
    wait_idle();

    configure(BASE_SPARE, TYPE_U64, 1'b0);
    push_text("9", 1'b1);

    target = planned + RANDOM_ITEMS;
    while (planned < target) begin
      wait_idle();
      configure(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
      repeat ($urandom_range(40, 60)) begin
        if (planned < target) push_random_string();
      end
    end
    wait_idle();

    if (fail_count == 0) begin
      $display("PASS ascii_integer_parser");
    end else begin
      $display("FAIL ascii_integer_parser");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/aip_pkg.sv
rtl/core/aip_accumulate.sv
rtl/core/aip_finish.sv
rtl/core/ascii_integer_parser.sv
sim/tb_ascii_integer_parser.sv
